[rtl/core/phc_pkg.sv]
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types, register codes and saturation for the pinhole camera unit.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X      = 4'd0,
    REG_FOCAL_Y      = 4'd1,
    REG_CENTRE_X     = 4'd2,
    REG_CENTRE_Y     = 4'd3,
    REG_INV_FOCAL_X  = 4'd4,
    REG_INV_FOCAL_Y  = 4'd5,
    REG_INV_CENTRE_X = 4'd6,
    REG_INV_CENTRE_Y = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [30:0] fx;
    logic        [30:0] fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] ifx;
    logic signed [31:0] ify;
    logic signed [31:0] icx;
    logic signed [31:0] icy;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fx:  31'd32768000,
    fy:  31'd32768000,
    cx:  32'sd20971520,
    cy:  32'sd15728640,
    ifx: 32'sd2147484,
    ify: 32'sd2147484,
    icx: -32'sd687194767,
    icy: -32'sd515396076
  };

  // fields carried unchanged through the divider to the output
  typedef struct packed {
    logic               mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] d;
    logic signed [31:0] m1a;
    logic signed [31:0] m1b;
  } pass_t;

  typedef struct packed {
    pass_t       p;
    logic        neg_a;
    logic        neg_b;
    logic        nz_a;
    logic        nz_b;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [31:0] den;
  } front_t;

  typedef struct packed {
    pass_t              p;
    logic signed [31:0] qa;
    logic signed [31:0] qb;
  } divres_t;

  // sign/magnitude to signed 32 bit with saturation
  function automatic logic signed [31:0] sat32(input logic neg, input logic over,
                                               input logic [31:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      if (over || mag > 32'h8000_0000) r = 32'sh8000_0000;
      else r = $signed(~mag + 32'd1);
    end else begin
      if (over || mag[31]) r = 32'sh7FFF_FFFF;
      else r = $signed(mag);
    end
    return r;
  endfunction

endpackage

[rtl/core/phc_front.sv]
// ----------------------------------------------------------------------------
// phc_front
// Products, numerator sums, sign/magnitude split and the back-projection
// multiply; six register stages.
// ----------------------------------------------------------------------------
module phc_front (
  input  logic                clk,
  input  logic                rst,
  input  phc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic signed [31:0]  coord_a,
  input  logic signed [31:0]  coord_b,
  input  logic signed [31:0]  depth_in,
  output logic                out_valid,
  input  logic                out_ready,
  output phc_pkg::front_t     out_data
);

  localparam int N = 6;

  logic [N-1:0] v;
  logic [N:0]   adv;

  logic               m1, m2;
  logic signed [31:0] a1, b1, d1, a2, b2, d2;
  logic signed [63:0] pa1, pb1, pc1, pd1, na2, nb2;
  logic [63:0]        pla4, pha4, plb4, phb4;
  logic [95:0]        fa5, fb5;
  phc_pkg::front_t    f3, f4, f5, f6;
  phc_pkg::front_t    f6_next;

  logic signed [32:0] opa, opb;
  logic signed [64:0] pa_w, pb_w;
  logic signed [63:0] add_a, add_b;
  logic [63:0]        mag_a, mag_b;
  logic [31:0]        mag_d;

  always_comb begin
    adv[N] = out_ready;
    for (int k = N - 1; k >= 0; k--) adv[k] = ~v[k] | adv[k+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = v[N-1];
  assign out_data  = f6;

  assign opa  = mode ? {cfg.ifx[31], cfg.ifx} : $signed({2'b00, cfg.fx});
  assign opb  = mode ? {cfg.ify[31], cfg.ify} : $signed({2'b00, cfg.fy});
  assign pa_w = coord_a * opa;
  assign pb_w = coord_b * opb;

  assign add_a = m1 ? {{16{cfg.icx[31]}}, cfg.icx, 16'd0} : pc1;
  assign add_b = m1 ? {{16{cfg.icy[31]}}, cfg.icy, 16'd0} : pd1;

  assign mag_a = na2[63] ? (~na2 + 64'd1) : na2;
  assign mag_b = nb2[63] ? (~nb2 + 64'd1) : nb2;
  assign mag_d = d2[31] ? (~d2 + 32'd1) : d2;

  always_comb begin
    f6_next       = f5;
    f6_next.p.m1a = phc_pkg::sat32(f5.neg_a, |fa5[95:78], fa5[77:46]);
    f6_next.p.m1b = phc_pkg::sat32(f5.neg_b, |fb5[95:78], fb5[77:46]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m1  <= mode;
      a1  <= coord_a;
      b1  <= coord_b;
      d1  <= depth_in;
      pa1 <= pa_w[63:0];
      pb1 <= pb_w[63:0];
      pc1 <= cfg.cx * depth_in;
      pd1 <= cfg.cy * depth_in;
    end
    if (adv[1]) begin
      m2  <= m1;
      a2  <= a1;
      b2  <= b1;
      d2  <= d1;
      na2 <= pa1 + add_a;
      nb2 <= pb1 + add_b;
    end
    if (adv[2]) begin
      f3.p.mode <= m2;
      f3.p.a    <= a2;
      f3.p.b    <= b2;
      f3.p.d    <= d2;
      f3.p.m1a  <= '0;
      f3.p.m1b  <= '0;
      f3.neg_a  <= na2[63] ^ d2[31];
      f3.neg_b  <= nb2[63] ^ d2[31];
      f3.nz_a   <= na2 != 64'sd0;
      f3.nz_b   <= nb2 != 64'sd0;
      f3.mag_a  <= mag_a;
      f3.mag_b  <= mag_b;
      f3.den    <= mag_d;
    end
    if (adv[3]) begin
      f4   <= f3;
      pla4 <= f3.mag_a[31:0] * f3.den;
      pha4 <= f3.mag_a[63:32] * f3.den;
      plb4 <= f3.mag_b[31:0] * f3.den;
      phb4 <= f3.mag_b[63:32] * f3.den;
    end
    if (adv[4]) begin
      f5  <= f4;
      fa5 <= {pha4, 32'd0} + {32'd0, pla4};
      fb5 <= {phb4, 32'd0} + {32'd0, plb4};
    end
    if (adv[5]) begin
      f6 <= f6_next;
    end
  end

endmodule

[rtl/core/phc_div.sv]
// ----------------------------------------------------------------------------
// phc_div
// Pipelined restoring divider for both image axes, two quotient bits a
// stage, followed by a saturation stage.
// ----------------------------------------------------------------------------
module phc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phc_pkg::front_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output phc_pkg::divres_t  out_data
);

  localparam int STEPS = 16;
  localparam int N     = STEPS + 2;

  typedef struct packed {
    phc_pkg::pass_t p;
    logic [63:0]    acc_a;
    logic [63:0]    acc_b;
    logic [31:0]    den;
    logic           neg_a;
    logic           neg_b;
    logic           ovf_a;
    logic           ovf_b;
    logic           nz_a;
    logic           nz_b;
  } dstage_t;

  logic [N-1:0]     v;
  logic [N:0]       adv;
  dstage_t          st [STEPS+1];
  phc_pkg::divres_t res;

  // remainder in the upper half, numerator bits then quotient in the lower
  function automatic logic [63:0] div_step(input logic [63:0] acc, input logic [31:0] den);
    logic [32:0] r;
    logic        q;
    r = acc[63:31];
    q = r >= {1'b0, den};
    return {(q ? 32'(r - {1'b0, den}) : r[31:0]), acc[30:0], q};
  endfunction

  always_comb begin
    adv[N] = out_ready;
    for (int k = N - 1; k >= 0; k--) adv[k] = ~v[k] | adv[k+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = v[N-1];
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0].p     <= in_data.p;
      st[0].acc_a <= in_data.mag_a;
      st[0].acc_b <= in_data.mag_b;
      st[0].den   <= in_data.den;
      st[0].neg_a <= in_data.neg_a;
      st[0].neg_b <= in_data.neg_b;
      st[0].ovf_a <= in_data.nz_a && (in_data.mag_a[63:32] >= in_data.den);
      st[0].ovf_b <= in_data.nz_b && (in_data.mag_b[63:32] >= in_data.den);
      st[0].nz_a  <= in_data.nz_a;
      st[0].nz_b  <= in_data.nz_b;
    end
    for (int k = 1; k <= STEPS; k++) begin
      if (adv[k]) begin
        st[k].p     <= st[k-1].p;
        st[k].acc_a <= div_step(div_step(st[k-1].acc_a, st[k-1].den), st[k-1].den);
        st[k].acc_b <= div_step(div_step(st[k-1].acc_b, st[k-1].den), st[k-1].den);
        st[k].den   <= st[k-1].den;
        st[k].neg_a <= st[k-1].neg_a;
        st[k].neg_b <= st[k-1].neg_b;
        st[k].ovf_a <= st[k-1].ovf_a;
        st[k].ovf_b <= st[k-1].ovf_b;
        st[k].nz_a  <= st[k-1].nz_a;
        st[k].nz_b  <= st[k-1].nz_b;
      end
    end
    // zero numerator gives zero, also over a zero divisor
    if (adv[N-1]) begin
      res.p  <= st[STEPS].p;
      res.qa <= st[STEPS].nz_a ?
                phc_pkg::sat32(st[STEPS].neg_a, st[STEPS].ovf_a, st[STEPS].acc_a[31:0]) :
                32'sd0;
      res.qb <= st[STEPS].nz_b ?
                phc_pkg::sat32(st[STEPS].neg_b, st[STEPS].ovf_b, st[STEPS].acc_b[31:0]) :
                32'sd0;
    end
  end

endmodule

[rtl/core/pinhole_project_backproject_unit.sv]
// ----------------------------------------------------------------------------
// pinhole_project_backproject_unit
// Pinhole projection and back-projection in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The path from item accepted to result valid runs through 25 register stages
// (6 front, 18 divider, 1 output). Throughput: one item per cycle while the
// output is not stalled, as every stage is registered and each divider stage
// retires two quotient bits. Bubbles close up under output stall.
// Reset clears all valid bits and loads the default camera registers.
module pinhole_project_backproject_unit #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [phc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [31:0]                coord_a,
  input  logic signed [31:0]                coord_b,
  input  logic signed [31:0]                depth_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                res_a,
  output logic signed [31:0]                res_b,
  output logic signed [31:0]                res_depth,
  output logic                              inside_res,
  output logic                              div_fault
);

  localparam logic signed [31:0] LIM_U = 32'(IMAGE_WIDTH * 65536);
  localparam logic signed [31:0] LIM_V = 32'(IMAGE_HEIGHT * 65536);

  phc_pkg::cfg_t    cfg;
  phc_pkg::front_t  fr_data;
  phc_pkg::divres_t dv_data;
  logic             fr_valid, fr_ready, dv_valid, dv_ready;
  logic signed [31:0] pu, pv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= phc_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (phc_pkg::reg_idx_t'(cfg_index))
        phc_pkg::REG_FOCAL_X:      cfg.fx  <= cfg_data[30:0];
        phc_pkg::REG_FOCAL_Y:      cfg.fy  <= cfg_data[30:0];
        phc_pkg::REG_CENTRE_X:     cfg.cx  <= $signed(cfg_data);
        phc_pkg::REG_CENTRE_Y:     cfg.cy  <= $signed(cfg_data);
        phc_pkg::REG_INV_FOCAL_X:  cfg.ifx <= $signed(cfg_data);
        phc_pkg::REG_INV_FOCAL_Y:  cfg.ify <= $signed(cfg_data);
        phc_pkg::REG_INV_CENTRE_X: cfg.icx <= $signed(cfg_data);
        phc_pkg::REG_INV_CENTRE_Y: cfg.icy <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  phc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .coord_a   (coord_a),
    .coord_b   (coord_b),
    .depth_in  (depth_in),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  phc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  assign dv_ready = ~out_valid | out_ready;

  // pixel tested: computed one when projecting, input one when back-projecting
  assign pu = dv_data.p.mode ? dv_data.p.a : dv_data.qa;
  assign pv = dv_data.p.mode ? dv_data.p.b : dv_data.qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dv_ready) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready) begin
      res_a      <= dv_data.p.mode ? dv_data.p.m1a : dv_data.qa;
      res_b      <= dv_data.p.mode ? dv_data.p.m1b : dv_data.qb;
      res_depth  <= dv_data.p.mode ? dv_data.p.d : 32'sd0;
      inside_res <= (pu > 32'sd0) && (pu < LIM_U) && (pv > 32'sd0) && (pv < LIM_V);
      div_fault  <= ~dv_data.p.mode && (dv_data.p.d == 32'sd0);
    end
  end

endmodule
